/* hw/rtl/lcp_pkg.sv */
// lcp_pkg: widths, lane wiring and constants for the leading minor positivity check
// no dependencies; imported by lcp_lane, lcp_merge and the top level
package lcp_pkg;

  localparam int MATRIX_ORDER = 3;
  localparam int ENTRIES      = MATRIX_ORDER * MATRIX_ORDER;
  localparam int IN_W         = 16;
  localparam int PAIR_W       = 2 * IN_W;
  localparam int TRIPLE_W     = 3 * IN_W;
  localparam int MIN_W        = 49;
  localparam int LANES        = 6;
  localparam int IN_DATA_W    = ENTRIES * IN_W;
  localparam int OUT_FIELDS_W = 2 * MIN_W + 1;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int STAGES       = 4;

  // alignment of the smaller minors to q25.24
  localparam int SHIFT_ENTRY = 16;
  localparam int SHIFT_PAIR  = 8;

  localparam logic signed [MIN_W-1:0] POS_MAX = {1'b0, {(MIN_W-1){1'b1}}};

  // entry order in tdata: a00 a10 a20 a01 a11 a21 a02 a12 a22
  // lane k forms entry[x]*entry[y]*entry[z]; lanes 1, 2 and 5 are subtracted
  localparam int LANE_X [LANES] = '{0, 0, 3, 3, 6, 6};
  localparam int LANE_Y [LANES] = '{4, 7, 1, 7, 1, 4};
  localparam int LANE_Z [LANES] = '{8, 5, 8, 2, 5, 2};

  typedef struct packed {
    logic valid;
    logic last;
  } lcp_tag_t;

endpackage

/* hw/rtl/leading_minor_positivity_check.sv */
// leading_minor_positivity_check: an accepted input transaction reaches m_tvalid via the
// lane, merge and output registers; throughput one matrix per cycle, set by the six
// parallel multiply lanes feeding a stalling pipeline; any output stall holds every stage
// rst (synchronous, active high) empties the pipeline and sets the running minimum to the
// most positive q25.24 value; depends on lcp_pkg, lcp_lane, lcp_merge
module leading_minor_positivity_check
  import lcp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // a00, a10, a20, a01, a11, a21, a02, a12, a22 (16 bits each, signed q8.8)
  input  logic [IN_DATA_W-1:0]  s_tdata,
  input  logic                  s_tlast,   // is_last
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // point_minimum (49), overall_minimum (49), stable (1), zero padding
  output logic [OUT_DATA_W-1:0] m_tdata,
  output logic                  m_tlast    // batch_done
);

  // pipeline advance: every stage moves together unless the output register is stuck
  logic adv;
  logic ld;

  lcp_tag_t tag [STAGES];

  logic signed [IN_W-1:0]     entry  [ENTRIES];
  logic signed [PAIR_W-1:0]   pair   [LANES];
  logic signed [TRIPLE_W-1:0] triple [LANES];

  // stage 1/2 side path for the entry and the 2x2 minor
  logic signed [IN_W-1:0]   a00_s1;
  logic signed [PAIR_W:0]   det2;
  logic signed [MIN_W-1:0]  minor0;
  logic signed [MIN_W-1:0]  minor1;
  logic signed [MIN_W-1:0]  point_min;

  // output register and batch state
  logic signed [MIN_W-1:0]  running_min;
  logic signed [MIN_W-1:0]  running_min_next;
  logic signed [MIN_W-1:0]  overall_min;
  logic signed [MIN_W-1:0]  point_min_q;
  logic signed [MIN_W-1:0]  overall_min_q;
  logic                     stable_q;
  logic                     last_q;

  assign adv      = !m_tvalid || m_tready;
  assign ld       = adv && tag[STAGES-1].valid;
  assign s_tready = adv;

  // unpack the matrix entries from the input transaction
  always_comb begin
    for (int k = 0; k < ENTRIES; k++) begin
      entry[k] = s_tdata[k*IN_W +: IN_W];
    end
  end

  // six triple product lanes of the 3x3 expansion; lanes 0 and 2 also give the 2x2 terms
  for (genvar g = 0; g < LANES; g++) begin : g_lane
    lcp_lane u_lane (
      .clk    (clk),
      .en     (adv),
      .x      (entry[LANE_X[g]]),
      .y      (entry[LANE_Y[g]]),
      .z      (entry[LANE_Z[g]]),
      .pair   (pair[g]),
      .triple (triple[g])
    );
  end

  // 2x2 minor a00*a11 - a01*a10, one bit of headroom
  assign det2 = (PAIR_W+1)'(pair[0]) - (PAIR_W+1)'(pair[2]);

  always_ff @(posedge clk) begin
    if (adv) begin
      a00_s1 <= entry[0];
      minor0 <= MIN_W'(a00_s1) <<< SHIFT_ENTRY;
      minor1 <= MIN_W'(det2) <<< SHIFT_PAIR;
    end
  end

  lcp_merge u_merge (
    .clk       (clk),
    .en        (adv),
    .triple    (triple),
    .minor0    (minor0),
    .minor1    (minor1),
    .point_min (point_min)
  );

  // fold into the batch minimum; a batch end restores the reset value
  assign overall_min      = (point_min < running_min) ? point_min : running_min;
  assign running_min_next = tag[STAGES-1].last ? POS_MAX : overall_min;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < STAGES; s++) begin
        tag[s] <= '0;
      end
      m_tvalid    <= 1'b0;
      running_min <= POS_MAX;
    end else if (adv) begin
      tag[0] <= '{valid: s_tvalid, last: s_tlast};
      for (int s = 1; s < STAGES; s++) begin
        tag[s] <= tag[s-1];
      end
      m_tvalid <= tag[STAGES-1].valid;
      if (tag[STAGES-1].valid) begin
        running_min <= running_min_next;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (ld) begin
      point_min_q   <= point_min;
      overall_min_q <= overall_min;
      stable_q      <= (overall_min > 0);
      last_q        <= tag[STAGES-1].last;
    end
  end

  assign m_tdata = {{(OUT_DATA_W-OUT_FIELDS_W){1'b0}}, stable_q, overall_min_q, point_min_q};
  assign m_tlast = last_q;

  // the batch minimum never exceeds the minimum of the matrix it reports
  a_overall_le_point: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (overall_min_q <= point_min_q))
    else $error("overall minimum above point minimum");

  // a batch end returns the running minimum to its reset value
  a_batch_restart: assert property (@(posedge clk) disable iff (rst)
    (ld && tag[STAGES-1].last) |=> (running_min == POS_MAX))
    else $error("running minimum not restored after batch end");

  // a stalled pipeline keeps its items and its batch state
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !adv |=> ($stable(tag[STAGES-1]) && $stable(running_min)))
    else $error("pipeline moved while stalled");

  // a result can only follow from an item that reached the last stage
  a_result_origin: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(tag[STAGES-1].valid))
    else $error("result without a source transaction");

endmodule

/* hw/rtl/lcp_lane.sv */
// lcp_lane: one triple product lane, pair product then product with the third entry
// depends on lcp_pkg
module lcp_lane
  import lcp_pkg::*;
(
  input  logic                       clk,
  input  logic                       en,
  input  logic signed [IN_W-1:0]     x,
  input  logic signed [IN_W-1:0]     y,
  input  logic signed [IN_W-1:0]     z,
  output logic signed [PAIR_W-1:0]   pair,
  output logic signed [TRIPLE_W-1:0] triple
);

  logic signed [IN_W-1:0] z_q;

  always_ff @(posedge clk) begin
    if (en) begin
      pair   <= PAIR_W'(x) * PAIR_W'(y);
      z_q    <= z;
      triple <= TRIPLE_W'(pair) * TRIPLE_W'(z_q);
    end
  end

endmodule

/* hw/rtl/lcp_merge.sv */
// lcp_merge: folds the six lane products into the 3x3 determinant and picks the least minor
// depends on lcp_pkg
module lcp_merge
  import lcp_pkg::*;
(
  input  logic                       clk,
  input  logic                       en,
  input  logic signed [TRIPLE_W-1:0] triple [LANES],
  input  logic signed [MIN_W-1:0]    minor0,
  input  logic signed [MIN_W-1:0]    minor1,
  output logic signed [MIN_W-1:0]    point_min
);

  logic signed [MIN_W-1:0] s0;
  logic signed [MIN_W-1:0] s1;
  logic signed [MIN_W-1:0] s2;
  logic signed [MIN_W-1:0] min01;
  logic signed [MIN_W-1:0] det;

  assign det = s0 + s1 + s2;

  always_ff @(posedge clk) begin
    if (en) begin
      // signed pair sums of the expansion
      s0        <= MIN_W'(triple[0]) - MIN_W'(triple[1]);
      s1        <= MIN_W'(triple[3]) - MIN_W'(triple[2]);
      s2        <= MIN_W'(triple[4]) - MIN_W'(triple[5]);
      min01     <= (minor1 < minor0) ? minor1 : minor0;
      point_min <= (det < min01) ? det : min01;
    end
  end

endmodule
